FILE: rtl/core/shrb_pkg.sv
package shrb_pkg;

	localparam int FIFO_DEPTH_DEF = 32;
	localparam int PORT_COUNT_DEF = 4;
	localparam int CFG_IDX_W      = 2;

	typedef enum logic [2:0] {
		ACT_HOST_RD  = 3'd0,
		ACT_HOST_WR  = 3'd1,
		ACT_PM_RD    = 3'd2,
		ACT_PM_WR    = 3'd3,
		ACT_BUS_BYTE = 3'd4,
		ACT_BUS_DONE = 3'd5,
		ACT_BUS_FET  = 3'd6
	} action_t;

	// host register offsets
	localparam logic [7:0] OFF_STATUS = 8'd0;
	localparam logic [7:0] OFF_CTRL   = 8'd2;
	localparam logic [7:0] OFF_CMD    = 8'd3;
	localparam logic [7:0] OFF_ADDR   = 8'd4;
	localparam logic [7:0] OFF_DAT0   = 8'd5;
	localparam logic [7:0] OFF_DAT1   = 8'd6;
	localparam logic [7:0] OFF_BLK    = 8'd7;

	// pm indexes
	localparam logic [7:0] PM_IDX_ENABLE = 8'd0;
	localparam logic [7:0] PM_IDX_BASE   = 8'd1;
	localparam logic [7:0] PM_IDX_PSEL   = 8'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PM_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PM_BASE   = 2'd1;
	localparam logic [7:0] PM_ENABLE_RST = 8'h10;
	localparam logic [7:0] PM_BASE_RST   = 8'h0B;

	// status bits
	localparam logic [4:0] ST_BUSY   = 5'h01;
	localparam logic [4:0] ST_DONE   = 5'h02;
	localparam logic [4:0] ST_DEVERR = 5'h04;
	localparam logic [4:0] ST_COLL   = 5'h08;
	localparam logic [4:0] ST_FAIL   = 5'h10;
	localparam logic [4:0] ST_W1C    = 5'h1E;

	// control register fields
	localparam logic [7:0] CNT_START = 8'h40;
	localparam int         CNT_SIZE_LSB = 2;

	// protocol sizes
	localparam logic [2:0] SZ_BYTE      = 3'd1;
	localparam logic [2:0] SZ_BYTE_DATA = 3'd2;
	localparam logic [2:0] SZ_WORD      = 3'd3;
	localparam logic [2:0] SZ_BLOCK     = 3'd5;

	// completion codes
	localparam logic [7:0] DONE_OK     = 8'd0;
	localparam logic [7:0] DONE_DEVERR = 8'd1;
	localparam logic [7:0] DONE_COLL   = 8'd2;

	// port select field in the pm byte
	localparam int PSEL_LSB = 3;

endpackage

FILE: rtl/core/smbus_host_register_block_unit.sv
// SMBus host register front end: takes one request per cycle unless stalled (host register
// and PM index accesses, bus byte/fetch/done events) and returns one result for each from
// the output register, in order. All register state updates at acceptance; the block-data
// FIFO is a single synchronous memory with one write and one read port, read data lands in
// the first stage and is merged into the output register, so back-to-back FIFO accesses
// run at full rate. A result waiting on a stalled output holds back the next request only
// while the first stage is full. The FIFO needs no clearing pass after reset.
module smbus_host_register_block_unit #(
	parameter int FIFO_DEPTH = shrb_pkg::FIFO_DEPTH_DEF,
	parameter int PORT_COUNT = shrb_pkg::PORT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [shrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic [7:0]                    offset,
	input  logic [7:0]                    wdata,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    rdata,
	output logic                          launch,
	output logic [1:0]                    launch_port,
	output logic [7:0]                    launch_addr,
	output logic [7:0]                    launch_cmd,
	output logic [2:0]                    launch_proto,
	output logic [7:0]                    launch_dat0,
	output logic [7:0]                    launch_dat1
);

	localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int IW = $clog2(FIFO_DEPTH + 1);
	localparam int CW = $clog2(FIFO_DEPTH + 2);
	localparam logic [IW-1:0] IDX_END = IW'(FIFO_DEPTH);
	localparam logic [CW-1:0] RX_LIM  = CW'(FIFO_DEPTH + 1);
	localparam logic [CW-1:0] RX_DEP  = CW'(FIFO_DEPTH);
	localparam logic [2:0]    PC      = 3'(PORT_COUNT);
	localparam logic [1:0]    PORT_LAST = 2'(PORT_COUNT - 1);

	// architectural registers
	logic [7:0]    pm_en_q, pm_base_q, psel_q;
	logic [4:0]    status_q;
	logic [2:0]    size_q;
	logic [7:0]    addr_q, cmd_q, dat0_q, dat1_q;
	logic [IW-1:0] fidx_q;
	logic [CW-1:0] rx_q;

	logic [7:0]    fifo_mem [FIFO_DEPTH];
	logic [7:0]    mem_rd_q;

	// next values
	logic [4:0]    status_n;
	logic [2:0]    size_n;
	logic [7:0]    addr_n, cmd_n, dat0_n, dat1_n, psel_n;
	logic [IW-1:0] fidx_n;
	logic [CW-1:0] rx_n, rx_m1;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    rdata_c;
	logic          use_mem_c;
	logic          launch_c;
	logic [1:0]    port_c;
	logic [4:0]    done_set;

	// stage 1
	logic          v_s1;
	logic [7:0]    rdata_s1;
	logic          use_mem_s1;
	logic          launch_s1;
	logic [1:0]    port_s1;
	logic [7:0]    addr_s1, cmd_s1, dat0_s1, dat1_s1;
	logic [2:0]    proto_s1;

	logic          acc, adv;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = v_s1 && !adv;
	assign acc       = in_valid && !in_stall;
	assign rx_m1     = rx_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_en_q   <= shrb_pkg::PM_ENABLE_RST;
			pm_base_q <= shrb_pkg::PM_BASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == shrb_pkg::CFG_PM_ENABLE) begin
				pm_en_q <= cfg_data;
			end
			if (cfg_index == shrb_pkg::CFG_PM_BASE) begin
				pm_base_q <= cfg_data;
			end
		end
	end

	always_comb begin
		status_n  = status_q;
		size_n    = size_q;
		addr_n    = addr_q;
		cmd_n     = cmd_q;
		dat0_n    = dat0_q;
		dat1_n    = dat1_q;
		psel_n    = psel_q;
		fidx_n    = fidx_q;
		rx_n      = rx_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = fidx_q[AW-1:0];
		mem_raddr = fidx_q[AW-1:0];
		rdata_c   = 8'd0;
		use_mem_c = 1'b0;
		launch_c  = 1'b0;
		done_set  = shrb_pkg::ST_FAIL;
		port_c    = psel_q[shrb_pkg::PSEL_LSB +: 2];
		if ({1'b0, port_c} >= PC) begin
			port_c = PORT_LAST;
		end
		case (shrb_pkg::action_t'(action))
			shrb_pkg::ACT_HOST_RD: begin
				case (offset)
					shrb_pkg::OFF_STATUS: rdata_c = {3'd0, status_q};
					shrb_pkg::OFF_CTRL: begin
						rdata_c = {3'd0, size_q, 2'd0};
						fidx_n  = '0;
					end
					shrb_pkg::OFF_CMD:  rdata_c = cmd_q;
					shrb_pkg::OFF_ADDR: rdata_c = addr_q;
					shrb_pkg::OFF_DAT0: rdata_c = dat0_q;
					shrb_pkg::OFF_DAT1: rdata_c = dat1_q;
					shrb_pkg::OFF_BLK: begin
						if (fidx_q < IDX_END) begin
							mem_re    = 1'b1;
							use_mem_c = 1'b1;
							fidx_n    = fidx_q + IW'(1);
						end
					end
					default: rdata_c = 8'd0;
				endcase
			end
			shrb_pkg::ACT_HOST_WR: begin
				case (offset)
					shrb_pkg::OFF_STATUS: status_n = status_q & ~(wdata[4:0] & shrb_pkg::ST_W1C);
					shrb_pkg::OFF_CTRL: begin
						if ((status_q & shrb_pkg::ST_BUSY) == 5'd0) begin
							size_n = wdata[shrb_pkg::CNT_SIZE_LSB +: 3];
							if ((wdata & shrb_pkg::CNT_START) != 8'd0) begin
								status_n = status_q | shrb_pkg::ST_BUSY;
								rx_n     = '0;
								launch_c = 1'b1;
							end
						end
					end
					shrb_pkg::OFF_CMD:  cmd_n  = wdata;
					shrb_pkg::OFF_ADDR: addr_n = wdata;
					shrb_pkg::OFF_DAT0: dat0_n = wdata;
					shrb_pkg::OFF_DAT1: dat1_n = wdata;
					shrb_pkg::OFF_BLK: begin
						if (fidx_q < IDX_END) begin
							mem_we = 1'b1;
							fidx_n = fidx_q + IW'(1);
						end
					end
					default: rdata_c = 8'd0;
				endcase
			end
			shrb_pkg::ACT_PM_RD: begin
				if (offset == shrb_pkg::PM_IDX_ENABLE) begin
					rdata_c = pm_en_q;
				end else if (offset == shrb_pkg::PM_IDX_BASE) begin
					rdata_c = pm_base_q;
				end else if (offset == shrb_pkg::PM_IDX_PSEL) begin
					rdata_c = psel_q;
				end
			end
			shrb_pkg::ACT_PM_WR: begin
				if (offset == shrb_pkg::PM_IDX_PSEL) begin
					psel_n = wdata;
				end
			end
			shrb_pkg::ACT_BUS_BYTE: begin
				// only while busy on a read transfer
				if (status_q[0] && addr_q[0]) begin
					mem_waddr = rx_m1[AW-1:0];
					case (size_q)
						shrb_pkg::SZ_BYTE, shrb_pkg::SZ_BYTE_DATA: begin
							if (rx_q == '0) dat0_n = wdata;
						end
						shrb_pkg::SZ_WORD: begin
							if (rx_q == '0) dat0_n = wdata;
							else if (rx_q == CW'(1)) dat1_n = wdata;
						end
						shrb_pkg::SZ_BLOCK: begin
							if (rx_q == '0) dat0_n = wdata;
							else if (rx_m1 < RX_DEP) mem_we = 1'b1;
						end
						default: mem_we = 1'b0;
					endcase
					if (rx_q < RX_LIM) rx_n = rx_q + CW'(1);
				end
			end
			shrb_pkg::ACT_BUS_DONE: begin
				if (status_q[0]) begin
					if (wdata == shrb_pkg::DONE_OK) done_set = shrb_pkg::ST_DONE;
					else if (wdata == shrb_pkg::DONE_DEVERR) done_set = shrb_pkg::ST_DEVERR;
					else if (wdata == shrb_pkg::DONE_COLL) done_set = shrb_pkg::ST_COLL;
					status_n = (status_q & ~shrb_pkg::ST_BUSY) | done_set;
				end
			end
			shrb_pkg::ACT_BUS_FET: begin
				// only while busy on a write transfer
				if (status_q[0] && !addr_q[0]) begin
					mem_raddr = rx_m1[AW-1:0];
					case (size_q)
						shrb_pkg::SZ_BYTE_DATA: begin
							if (rx_q == '0) rdata_c = dat0_q;
						end
						shrb_pkg::SZ_WORD: begin
							if (rx_q == '0) rdata_c = dat0_q;
							else if (rx_q == CW'(1)) rdata_c = dat1_q;
						end
						shrb_pkg::SZ_BLOCK: begin
							if (rx_q == '0) begin
								rdata_c = dat0_q;
							end else if (rx_m1 < RX_DEP) begin
								mem_re    = 1'b1;
								use_mem_c = 1'b1;
							end
						end
						default: rdata_c = 8'd0;
					endcase
					if (rx_q < RX_LIM) rx_n = rx_q + CW'(1);
				end
			end
			default: rdata_c = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			size_q   <= '0;
			addr_q   <= '0;
			cmd_q    <= '0;
			dat0_q   <= '0;
			dat1_q   <= '0;
			psel_q   <= '0;
			fidx_q   <= '0;
			rx_q     <= '0;
		end else if (acc) begin
			status_q <= status_n;
			size_q   <= size_n;
			addr_q   <= addr_n;
			cmd_q    <= cmd_n;
			dat0_q   <= dat0_n;
			dat1_q   <= dat1_n;
			psel_q   <= psel_n;
			fidx_q   <= fidx_n;
			rx_q     <= rx_n;
		end
	end

	// block fifo memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (acc && mem_we) begin
			fifo_mem[mem_waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && mem_re) begin
			mem_rd_q <= fifo_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rdata_s1   <= rdata_c;
			use_mem_s1 <= use_mem_c;
			launch_s1  <= launch_c;
			port_s1    <= launch_c ? port_c : 2'd0;
			addr_s1    <= launch_c ? addr_q : 8'd0;
			cmd_s1     <= launch_c ? cmd_q : 8'd0;
			proto_s1   <= launch_c ? size_n : 3'd0;
			dat0_s1    <= launch_c ? dat0_q : 8'd0;
			dat1_s1    <= launch_c ? dat1_q : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			rdata        <= use_mem_s1 ? mem_rd_q : rdata_s1;
			launch       <= launch_s1;
			launch_port  <= port_s1;
			launch_addr  <= addr_s1;
			launch_cmd   <= cmd_s1;
			launch_proto <= proto_s1;
			launch_dat0  <= dat0_s1;
			launch_dat1  <= dat1_s1;
		end
	end

`ifndef SYNTHESIS
	a_port_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && launch |-> {1'b0, launch_port} < PC)
		else $error("launch port beyond the mux");

	a_fidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fidx_q <= IDX_END)
		else $error("fifo index past the end");

	a_rx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_q <= RX_LIM)
		else $error("transfer counter past its limit");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && launch_c |=> status_q[0] && v_s1 && launch_s1)
		else $error("start request did not set busy");
`endif

endmodule

FILE: tb/tb_top.sv
module tb_top;
	import shrb_pkg::*;

	localparam int FIFO_N = FIFO_DEPTH_DEF;
	localparam int FIFO_AW = $clog2(FIFO_N);
	localparam int GAP_PCT = 23;
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam logic [7:0] OFF_UNUSED = 8'd1;
	localparam logic [7:0] PM_IDX_NONE = 8'hFF;

	typedef struct packed {
		logic [7:0] rdata;
		logic       launch;
		logic [1:0] port;
		logic [7:0] addr;
		logic [7:0] cmd;
		logic [2:0] proto;
		logic [7:0] dat0;
		logic [7:0] dat1;
	} result_t;

	typedef struct packed {
		logic [2:0] act;
		logic [7:0] off;
		logic [7:0] dat;
		logic       typed;
		logic [7:0] rd;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [2:0] action;
	logic [7:0] offset;
	logic [7:0] wdata;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] rdata;
	logic launch;
	logic [1:0] launch_port;
	logic [7:0] launch_addr;
	logic [7:0] launch_cmd;
	logic [2:0] launch_proto;
	logic [7:0] launch_dat0;
	logic [7:0] launch_dat1;

	smbus_host_register_block_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.offset(offset),
		.wdata(wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rdata(rdata),
		.launch(launch),
		.launch_port(launch_port),
		.launch_addr(launch_addr),
		.launch_cmd(launch_cmd),
		.launch_proto(launch_proto),
		.launch_dat0(launch_dat0),
		.launch_dat1(launch_dat1)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted register state
	logic [4:0] st_bits;
	logic [2:0] size_r;
	logic [7:0] addr_r, cmd_r, dat0_r, dat1_r, psel_r;
	logic [7:0] pm_en_r, pm_base_r;
	logic [7:0] fifo_mem [FIFO_N];
	logic [FIFO_N-1:0] fifo_written;
	logic [5:0] fifo_idx;
	logic [5:0] xfer_cnt;

	result_t pending_results [$];
	int errors = 0;
	int items_sent = 0;
	bit gaps_on = 1'b1;
	bit next_typed = 1'b0;
	logic [7:0] next_rd = 8'h00;
	logic req_typed = 1'b0;
	logic [7:0] req_rd = 8'h00;
	row_t dir_rows [25];

	task automatic predict_access(input logic [2:0] act, input logic [7:0] off,
			input logic [7:0] dat, output result_t r);
		int k;
		int p;
		r = '0;
		k = int'(xfer_cnt);
		case (act)
			ACT_HOST_RD: begin
				case (off)
					OFF_STATUS: r.rdata = {3'b000, st_bits};
					OFF_CTRL: begin
						r.rdata = 8'(size_r) << CNT_SIZE_LSB;
						fifo_idx = '0;
					end
					OFF_CMD: r.rdata = cmd_r;
					OFF_ADDR: r.rdata = addr_r;
					OFF_DAT0: r.rdata = dat0_r;
					OFF_DAT1: r.rdata = dat1_r;
					OFF_BLK: if (int'(fifo_idx) < FIFO_N) begin
						r.rdata = fifo_mem[FIFO_AW'(fifo_idx)];
						fifo_idx = fifo_idx + 6'd1;
					end
					default: ;
				endcase
			end
			ACT_HOST_WR: begin
				case (off)
					OFF_STATUS: st_bits = st_bits & ~(dat[4:0] & ST_W1C);
					OFF_CTRL: if ((st_bits & ST_BUSY) == 5'd0) begin
						size_r = dat[CNT_SIZE_LSB +: 3];
						if ((dat & CNT_START) != 8'd0) begin
							p = int'(psel_r[PSEL_LSB +: 2]);
							if (p >= PORT_COUNT_DEF)
								p = PORT_COUNT_DEF - 1;
							st_bits = st_bits | ST_BUSY;
							xfer_cnt = '0;
							r.launch = 1'b1;
							r.port = 2'(p);
							r.addr = addr_r;
							r.cmd = cmd_r;
							r.proto = size_r;
							r.dat0 = dat0_r;
							r.dat1 = dat1_r;
						end
					end
					OFF_CMD: cmd_r = dat;
					OFF_ADDR: addr_r = dat;
					OFF_DAT0: dat0_r = dat;
					OFF_DAT1: dat1_r = dat;
					OFF_BLK: if (int'(fifo_idx) < FIFO_N) begin
						fifo_mem[FIFO_AW'(fifo_idx)] = dat;
						fifo_written[FIFO_AW'(fifo_idx)] = 1'b1;
						fifo_idx = fifo_idx + 6'd1;
					end
					default: ;
				endcase
			end
			ACT_PM_RD: begin
				if (off == PM_IDX_ENABLE)
					r.rdata = pm_en_r;
				else if (off == PM_IDX_BASE)
					r.rdata = pm_base_r;
				else if (off == PM_IDX_PSEL)
					r.rdata = psel_r;
			end
			ACT_PM_WR: if (off == PM_IDX_PSEL) psel_r = dat;
			ACT_BUS_BYTE: if ((st_bits & ST_BUSY) != 5'd0 && addr_r[0]) begin
				case (size_r)
					SZ_BYTE, SZ_BYTE_DATA: if (k == 0) dat0_r = dat;
					SZ_WORD: begin
						if (k == 0)
							dat0_r = dat;
						else if (k == 1)
							dat1_r = dat;
					end
					SZ_BLOCK: begin
						if (k == 0)
							dat0_r = dat;
						else if (k - 1 < FIFO_N) begin
							fifo_mem[FIFO_AW'(k - 1)] = dat;
							fifo_written[FIFO_AW'(k - 1)] = 1'b1;
						end
					end
					default: ;
				endcase
				if (k < FIFO_N + 1)
					xfer_cnt = xfer_cnt + 6'd1;
			end
			ACT_BUS_DONE: if ((st_bits & ST_BUSY) != 5'd0) begin
				st_bits = st_bits & ~ST_BUSY;
				if (dat == DONE_OK)
					st_bits = st_bits | ST_DONE;
				else if (dat == DONE_DEVERR)
					st_bits = st_bits | ST_DEVERR;
				else if (dat == DONE_COLL)
					st_bits = st_bits | ST_COLL;
				else
					st_bits = st_bits | ST_FAIL;
			end
			ACT_BUS_FET: if ((st_bits & ST_BUSY) != 5'd0 && !addr_r[0]) begin
				case (size_r)
					SZ_BYTE_DATA: if (k == 0) r.rdata = dat0_r;
					SZ_WORD: begin
						if (k == 0)
							r.rdata = dat0_r;
						else if (k == 1)
							r.rdata = dat1_r;
					end
					SZ_BLOCK: begin
						if (k == 0)
							r.rdata = dat0_r;
						else if (k - 1 < FIFO_N)
							r.rdata = fifo_mem[FIFO_AW'(k - 1)];
					end
					default: ;
				endcase
				if (k < FIFO_N + 1)
					xfer_cnt = xfer_cnt + 6'd1;
			end
			default: ;
		endcase
	endtask

	// true when the request would read a fifo entry nobody has written yet
	function automatic bit reads_unwritten(input logic [2:0] act, input logic [7:0] off);
		int k;
		k = int'(xfer_cnt);
		if (act == ACT_HOST_RD && off == OFF_BLK && int'(fifo_idx) < FIFO_N)
			return !fifo_written[FIFO_AW'(fifo_idx)];
		if (act == ACT_BUS_FET && (st_bits & ST_BUSY) != 5'd0 && !addr_r[0]
				&& size_r == SZ_BLOCK && k >= 1 && k - 1 < FIFO_N)
			return !fifo_written[FIFO_AW'(k - 1)];
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : monitor
		result_t r;
		result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_access(action, offset, wdata, r);
				if (req_typed) begin
					r = '0;
					r.rdata = req_rd;
				end
				pending_results.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no request pending", 1, 0);
				end else begin
					want = pending_results.pop_front();
					if (rdata !== want.rdata)
						report_mismatch("rdata", int'(rdata), int'(want.rdata));
					if (launch !== want.launch)
						report_mismatch("launch", int'(launch), int'(want.launch));
					if (launch_port !== want.port)
						report_mismatch("launch_port", int'(launch_port), int'(want.port));
					if (launch_addr !== want.addr)
						report_mismatch("launch_addr", int'(launch_addr), int'(want.addr));
					if (launch_cmd !== want.cmd)
						report_mismatch("launch_cmd", int'(launch_cmd), int'(want.cmd));
					if (launch_proto !== want.proto)
						report_mismatch("launch_proto", int'(launch_proto),
							int'(want.proto));
					if (launch_dat0 !== want.dat0)
						report_mismatch("launch_dat0", int'(launch_dat0), int'(want.dat0));
					if (launch_dat1 !== want.dat1)
						report_mismatch("launch_dat1", int'(launch_dat1), int'(want.dat1));
				end
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
	end

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input logic [2:0] act, input logic [7:0] off, input logic [7:0] dat);
		if (reads_unwritten(act, off)) begin
			if (act == ACT_HOST_RD) begin
				act = ACT_HOST_WR;
			end else begin
				act = ACT_PM_RD;
				off = PM_IDX_ENABLE;
			end
		end
		while (gaps_on && $urandom_range(99) < GAP_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		offset = off;
		wdata = dat;
		req_typed = next_typed;
		req_rd = next_rd;
		next_typed = 1'b0;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_PM_ENABLE)
			pm_en_r = val;
		else if (idx == CFG_PM_BASE)
			pm_base_r = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// set up, launch, run bus events, complete, then read back
	task automatic run_transfer();
		logic [7:0] a;
		logic [2:0] sz;
		logic [7:0] ctrl;
		int pick;
		int n;
		a = 8'($urandom);
		send_req(ACT_HOST_WR, OFF_ADDR, a);
		if ($urandom_range(1) == 0) send_req(ACT_HOST_WR, OFF_CMD, 8'($urandom));
		if ($urandom_range(1) == 0) send_req(ACT_HOST_WR, OFF_DAT0, 8'($urandom));
		if ($urandom_range(1) == 0) send_req(ACT_HOST_WR, OFF_DAT1, 8'($urandom));
		if ($urandom_range(3) == 0) send_req(ACT_PM_WR, PM_IDX_PSEL, 8'($urandom));
		pick = $urandom_range(9);
		case (pick)
			0, 1, 2: sz = SZ_BLOCK;
			3: sz = SZ_WORD;
			4: sz = SZ_BYTE_DATA;
			5: sz = SZ_BYTE;
			6: sz = 3'($urandom);
			default: sz = SZ_WORD;
		endcase
		ctrl = (8'($urandom) & 8'hA3) | CNT_START | (8'(sz) << CNT_SIZE_LSB);
		send_req(ACT_HOST_WR, OFF_CTRL, ctrl);
		if ($urandom_range(4) == 0) send_req(ACT_HOST_WR, OFF_CTRL, 8'($urandom));
		if (sz == SZ_BLOCK)
			n = ($urandom_range(7) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
		else
			n = $urandom_range(0, 3);
		for (int i = 0; i < n; i++) begin
			// now and then an event from the wrong direction
			if (a[0] ^ ($urandom_range(9) == 0))
				send_req(ACT_BUS_BYTE, 8'($urandom), 8'($urandom));
			else
				send_req(ACT_BUS_FET, 8'($urandom), 8'($urandom));
		end
		send_req(ACT_BUS_DONE, 8'($urandom),
			($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
		if ($urandom_range(9) == 0) send_req(ACT_BUS_DONE, 8'($urandom), 8'($urandom));
		send_req(ACT_HOST_RD, OFF_STATUS, 8'($urandom));
		send_req(ACT_HOST_RD, OFF_DAT0, 8'($urandom));
		send_req(ACT_HOST_RD, OFF_DAT1, 8'($urandom));
		if (sz == SZ_BLOCK && a[0]) begin
			send_req(ACT_HOST_RD, OFF_CTRL, 8'($urandom));
			for (int i = 0; i < n; i++)
				send_req(ACT_HOST_RD, OFF_BLK, 8'($urandom));
		end
		send_req(ACT_HOST_WR, OFF_STATUS, ($urandom_range(1) == 0) ? 8'hFF : 8'($urandom));
	endtask

	task automatic run_block_fill();
		int n;
		send_req(ACT_HOST_RD, OFF_CTRL, 8'($urandom));
		n = ($urandom_range(5) == 0) ? $urandom_range(32, 36) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			send_req(ACT_HOST_WR, OFF_BLK, 8'($urandom));
		if ($urandom_range(1) == 0) begin
			send_req(ACT_HOST_RD, OFF_CTRL, 8'($urandom));
			n = ($urandom_range(5) == 0) ? $urandom_range(32, 36) : $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_req(ACT_HOST_RD, OFF_BLK, 8'($urandom));
		end
	endtask

	task automatic run_random(input int n_items);
		int target;
		int kind;
		target = items_sent + n_items;
		while (items_sent < target) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				run_transfer();
			end else if (kind < 70) begin
				run_block_fill();
			end else begin
				repeat ($urandom_range(1, 4))
					send_req(3'($urandom),
						($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7)),
						8'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PM_ENABLE;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		action = ACT_HOST_RD;
		offset = OFF_STATUS;
		wdata = 8'h00;

		st_bits = '0;
		size_r = '0;
		addr_r = '0;
		cmd_r = '0;
		dat0_r = '0;
		dat1_r = '0;
		psel_r = '0;
		pm_en_r = PM_ENABLE_RST;
		pm_base_r = PM_BASE_RST;
		fifo_written = '0;
		fifo_idx = '0;
		xfer_cnt = '0;
		foreach (fifo_mem[i])
			fifo_mem[i] = 8'h00;

		dir_rows = '{
			'{ACT_HOST_RD,  OFF_STATUS,    8'h00, 1'b1, 8'h00},
			'{ACT_PM_RD,    PM_IDX_ENABLE, 8'h00, 1'b1, PM_ENABLE_RST},
			'{ACT_PM_RD,    PM_IDX_BASE,   8'h00, 1'b1, PM_BASE_RST},
			'{ACT_PM_RD,    PM_IDX_PSEL,   8'h00, 1'b1, 8'h00},
			'{ACT_PM_WR,    PM_IDX_ENABLE, 8'h55, 1'b0, 8'h00},
			'{ACT_PM_RD,    PM_IDX_ENABLE, 8'h00, 1'b1, PM_ENABLE_RST},
			'{ACT_PM_RD,    PM_IDX_NONE,   8'hFF, 1'b1, 8'h00},
			'{ACT_PM_WR,    PM_IDX_PSEL,   8'hFF, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_ADDR,      8'hA4, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_CMD,       8'hFF, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_DAT0,      8'h02, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_DAT1,      8'h00, 1'b0, 8'h00},
			'{ACT_HOST_RD,  OFF_CTRL,      8'h00, 1'b1, 8'h00},
			'{ACT_HOST_WR,  OFF_BLK,       8'h11, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_BLK,       8'hEE, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_CTRL,      8'h54, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_CTRL,      8'h48, 1'b0, 8'h00},
			'{ACT_BUS_FET,  OFF_STATUS,    8'h00, 1'b0, 8'h00},
			'{ACT_BUS_FET,  OFF_STATUS,    8'h00, 1'b0, 8'h00},
			'{ACT_BUS_FET,  OFF_STATUS,    8'h00, 1'b0, 8'h00},
			'{ACT_BUS_DONE, OFF_STATUS,    8'hFF, 1'b0, 8'h00},
			'{ACT_HOST_RD,  OFF_STATUS,    8'h00, 1'b0, 8'h00},
			'{ACT_HOST_WR,  OFF_STATUS,    8'hFF, 1'b0, 8'h00},
			'{ACT_HOST_RD,  OFF_UNUSED,    8'h00, 1'b1, 8'h00},
			'{ACT_UNUSED,   PM_IDX_NONE,   8'hFF, 1'b1, 8'h00}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			next_typed = dir_rows[i].typed;
			next_rd = dir_rows[i].rd;
			send_req(dir_rows[i].act, dir_rows[i].off, dir_rows[i].dat);
		end

		write_reg(CFG_PM_ENABLE, 8'h00);
		write_reg(CFG_PM_BASE, 8'hFF);
		run_random(500);

		// stretch with no gaps on either side
		write_reg(CFG_PM_ENABLE, 8'hFF);
		write_reg(CFG_PM_BASE, 8'h00);
		gaps_on = 1'b0;
		run_random(500);
		gaps_on = 1'b1;

		write_reg(CFG_PM_ENABLE, 8'($urandom));
		write_reg(CFG_PM_BASE, 8'($urandom));
		run_random(250);
		wait_idle();
		run_random(250);

		write_reg(CFG_PM_ENABLE, PM_ENABLE_RST);
		write_reg(CFG_PM_BASE, PM_BASE_RST);
		run_random(500);

		wait_idle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[smbus_host_register_block_unit] OK");
		else
			$display("[smbus_host_register_block_unit] ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("[smbus_host_register_block_unit] ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/shrb_pkg.sv
rtl/core/smbus_host_register_block_unit.sv
tb/tb_top.sv
